@@ rtl/lktk_pkg.sv @@
package lktk_pkg;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic TABLE_LOW  = 1'b0;
  localparam logic TABLE_HIGH = 1'b1;

  typedef enum logic {
    TBL_IDLE,
    TBL_SCAN
  } tbl_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_INSERT,
    TOP_DONE
  } top_state_t;

  typedef struct packed {
    logic        insert;
    logic        read;
    logic [31:0] value;
  } tbl_req_t;

  typedef struct packed {
    logic        busy;
    logic        entry_used;
    logic [31:0] entry_value;
    logic [31:0] entry_hits;
  } tbl_stat_t;

endpackage

@@ rtl/lktk_table.sv @@
module lktk_table #(
  parameter int TABLE_ENTRIES = 10,
  parameter bit DESCENDING    = 1'b0,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lktk_pkg::tbl_req_t   req,
  input  logic [IW-1:0]        rd_index,
  output lktk_pkg::tbl_stat_t  stat
);

  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  logic [31:0]     values_r [TABLE_ENTRIES];
  logic [31:0]     hits_r   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_r;

  lktk_pkg::tbl_state_t state_r, state_nxt;
  logic [IW-1:0]   idx_r;
  logic [31:0]     value_r;

  logic [31:0] cur_value;
  logic [31:0] cur_hits;
  logic        cur_used;
  logic        is_equal;
  logic        goes_before;
  logic        do_hit;
  logic        do_insert;

  // one compare unit, walked over the table by idx_r
  always_comb begin
    cur_value   = values_r[idx_r];
    cur_hits    = hits_r[idx_r];
    cur_used    = used_r[idx_r];
    is_equal    = (value_r == cur_value);
    if (DESCENDING) begin
      goes_before = !cur_used || (value_r > cur_value);
    end else begin
      goes_before = !cur_used || (value_r < cur_value);
    end
    do_hit    = (state_r == lktk_pkg::TBL_SCAN) && cur_used && is_equal;
    do_insert = (state_r == lktk_pkg::TBL_SCAN) && !do_hit && goes_before;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lktk_pkg::TBL_IDLE: begin
        if (req.insert) state_nxt = lktk_pkg::TBL_SCAN;
      end
      lktk_pkg::TBL_SCAN: begin
        if (do_hit || do_insert || (idx_r == LAST)) state_nxt = lktk_pkg::TBL_IDLE;
      end
      default: state_nxt = lktk_pkg::TBL_IDLE;
    endcase
  end

  always_comb begin
    stat.busy        = (state_r == lktk_pkg::TBL_SCAN);
    stat.entry_used  = cur_used;
    stat.entry_value = cur_value;
    stat.entry_hits  = cur_hits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lktk_pkg::TBL_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lktk_pkg::TBL_IDLE) begin
        if (req.insert) begin
          idx_r <= '0;
        end else if (req.read) begin
          idx_r <= rd_index;
        end
      end else if (state_nxt == lktk_pkg::TBL_SCAN) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == lktk_pkg::TBL_IDLE) && req.insert) value_r <= req.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (do_insert) begin
      for (int j = 1; j < TABLE_ENTRIES; j++) begin
        if (IW'(j) > idx_r) used_r[j] <= used_r[j-1];
      end
      used_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_hit) begin
      if (cur_hits != '1) hits_r[idx_r] <= cur_hits + 32'd1;
    end else if (do_insert) begin
      // later entries move one place toward the end, the last drops off
      for (int j = 1; j < TABLE_ENTRIES; j++) begin
        if (IW'(j) > idx_r) begin
          values_r[j] <= values_r[j-1];
          hits_r[j]   <= hits_r[j-1];
        end
      end
      values_r[idx_r] <= value_r;
      hits_r[idx_r]   <= 32'd1;
    end
  end

endmodule

@@ rtl/latency_top_k_tracker_top.sv @@
// record transaction: accept, then one table entry compared per cycle (up to
// TABLE_ENTRIES entries, both tables scanned side by side), the INSERT state sees the scan
// finish, and the DONE state loads the result
// a new transaction is accepted only after the last one has loaded its result
// a result held in the output register by out_stall keeps the next one waiting in DONE
// synchronous active-low reset clears out_valid, the table used bits and the summary statistics
module latency_top_k_tracker_top #(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_sample_latency,
  input  logic        in_read_table,
  input  logic [3:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_entry_valid,
  output logic [31:0] out_entry_latency,
  output logic [31:0] out_entry_hits,
  output logic [31:0] out_min_latency,
  output logic [31:0] out_max_latency,
  output logic [63:0] out_total_latency,
  output logic [31:0] out_sample_total
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  lktk_pkg::top_state_t state_r, state_nxt;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        in_range;
  logic [31:0] ridx_ext;
  logic [IW-1:0] rd_index;

  logic        cmd_r;
  logic        tsel_r;
  logic        range_r;

  logic [31:0] min_r;
  logic [31:0] max_r;
  logic [63:0] sum_r;
  logic [31:0] count_r;
  logic [64:0] sum_wide;

  lktk_pkg::tbl_req_t  req;
  lktk_pkg::tbl_stat_t low_stat;
  lktk_pkg::tbl_stat_t high_stat;
  lktk_pkg::tbl_stat_t sel_stat;

  logic        out_valid_r;
  logic        entry_valid_r;
  logic [31:0] entry_latency_r;
  logic [31:0] entry_hits_r;
  logic [31:0] min_out_r;
  logic [31:0] max_out_r;
  logic [63:0] sum_out_r;
  logic [31:0] count_out_r;

  assign ridx_ext = 32'(in_read_index);
  assign in_range = ridx_ext < 32'(TABLE_ENTRIES);
  assign rd_index = ridx_ext[IW-1:0];
  assign sum_wide = {1'b0, sum_r} + {33'b0, in_sample_latency};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lktk_pkg::TOP_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == lktk_pkg::CMD_RECORD) ? lktk_pkg::TOP_INSERT
                                                       : lktk_pkg::TOP_DONE;
        end
      end
      lktk_pkg::TOP_INSERT: begin
        if (!low_stat.busy && !high_stat.busy) state_nxt = lktk_pkg::TOP_DONE;
      end
      lktk_pkg::TOP_DONE: begin
        if (out_free) state_nxt = lktk_pkg::TOP_IDLE;
      end
      default: state_nxt = lktk_pkg::TOP_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != lktk_pkg::TOP_IDLE);
    accept     = in_valid && !in_stall;
    out_load   = (state_r == lktk_pkg::TOP_DONE) && out_free;
    req.insert = accept && (in_cmd == lktk_pkg::CMD_RECORD);
    req.read   = accept && (in_cmd == lktk_pkg::CMD_READ) && in_range;
    req.value  = in_sample_latency;
    sel_stat   = (tsel_r == lktk_pkg::TABLE_HIGH) ? high_stat : low_stat;
  end

  lktk_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .DESCENDING    (1'b0)
  ) u_low (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_index (rd_index),
    .stat     (low_stat)
  );

  lktk_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .DESCENDING    (1'b1)
  ) u_high (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_index (rd_index),
    .stat     (high_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lktk_pkg::TOP_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= '1;
      max_r       <= '0;
      sum_r       <= '0;
      count_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (req.insert) begin
        sum_r <= sum_wide[64] ? '1 : sum_wide[63:0];
        if (count_r != '1) count_r <= count_r + 32'd1;
        if (in_sample_latency < min_r) min_r <= in_sample_latency;
        if (in_sample_latency > max_r) max_r <= in_sample_latency;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      tsel_r  <= in_read_table;
      range_r <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if ((cmd_r == lktk_pkg::CMD_READ) && range_r && sel_stat.entry_used) begin
        entry_valid_r   <= 1'b1;
        entry_latency_r <= sel_stat.entry_value;
        entry_hits_r    <= sel_stat.entry_hits;
      end else begin
        entry_valid_r   <= 1'b0;
        entry_latency_r <= '0;
        entry_hits_r    <= '0;
      end
      min_out_r   <= min_r;
      max_out_r   <= max_r;
      sum_out_r   <= sum_r;
      count_out_r <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_valid   = entry_valid_r;
  assign out_entry_latency = entry_latency_r;
  assign out_entry_hits    = entry_hits_r;
  assign out_min_latency   = min_out_r;
  assign out_max_latency   = max_out_r;
  assign out_total_latency = sum_out_r;
  assign out_sample_total  = count_out_r;

endmodule

@@ dv/tb_latency_top_k_tracker_top.sv @@
module tb_latency_top_k_tracker_top;

  localparam int DEPTH       = 10;
  localparam int RAND_ITEMS  = 1400;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    logic        cmd;
    logic [31:0] lat;
    logic        tbl;
    logic [3:0]  idx;
  } probe_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] entry_latency;
    logic [31:0] entry_hits;
    logic [31:0] min_latency;
    logic [31:0] max_latency;
    logic [63:0] total_latency;
    logic [31:0] sample_total;
  } stats_t;

  typedef struct packed {
    probe_t item;
    logic   typed;
    stats_t want;
  } plan_row_t;

  localparam stats_t RESET_STATS = '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 64'd0, 32'd0};

  localparam int PLAN_ROWS = 26;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_LOW,  4'd0},  1'b1, RESET_STATS},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_HIGH, 4'd15}, 1'b1, RESET_STATS},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_HIGH, 4'd9},  1'b1, RESET_STATS},
    // zero is a real value, not an empty marker
    '{'{lktk_pkg::CMD_RECORD, 32'd0,         lktk_pkg::TABLE_LOW,  4'd0},  1'b1,
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 32'd1}},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_LOW,  4'd0},  1'b1,
      '{1'b1, 32'd0, 32'd1, 32'd0, 32'd0, 64'd0, 32'd1}},
    '{'{lktk_pkg::CMD_RECORD, 32'hFFFF_FFFF, lktk_pkg::TABLE_LOW,  4'd0},  1'b1,
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 32'd2}},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_HIGH, 4'd0},  1'b1,
      '{1'b1, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 32'd2}},
    '{'{lktk_pkg::CMD_RECORD, 32'hFFFF_FFFF, lktk_pkg::TABLE_HIGH, 4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_HIGH, 4'd0},  1'b0, '0},
    // fill both tables past capacity, shifting and dropping entries
    '{'{lktk_pkg::CMD_RECORD, 32'd5,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd3,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd7,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd1,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd9,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd2,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd8,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd4,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd6,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd10,        lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd11,        lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_RECORD, 32'd0,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_LOW,  4'd9},  1'b0, '0},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_HIGH, 4'd9},  1'b0, '0},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_LOW,  4'd10}, 1'b0, '0},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_HIGH, 4'd15}, 1'b0, '0},
    '{'{lktk_pkg::CMD_READ,   32'd0,         lktk_pkg::TABLE_LOW,  4'd0},  1'b0, '0}
  };

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic        in_cmd            = lktk_pkg::CMD_RECORD;
  logic [31:0] in_sample_latency = '0;
  logic        in_read_table     = lktk_pkg::TABLE_LOW;
  logic [3:0]  in_read_index     = '0;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic        out_entry_valid;
  logic [31:0] out_entry_latency;
  logic [31:0] out_entry_hits;
  logic [31:0] out_min_latency;
  logic [31:0] out_max_latency;
  logic [63:0] out_total_latency;
  logic [31:0] out_sample_total;

  latency_top_k_tracker_top #(.TABLE_ENTRIES(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_sample_latency (in_sample_latency),
    .in_read_table     (in_read_table),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entry_valid   (out_entry_valid),
    .out_entry_latency (out_entry_latency),
    .out_entry_hits    (out_entry_hits),
    .out_min_latency   (out_min_latency),
    .out_max_latency   (out_max_latency),
    .out_total_latency (out_total_latency),
    .out_sample_total  (out_sample_total)
  );

  // tracker model: index 0 is the ascending table, index 1 the descending one
  logic [31:0] tk_value [2][DEPTH];
  logic [31:0] tk_hits  [2][DEPTH];
  logic        tk_used  [2][DEPTH];
  logic [31:0] tk_min;
  logic [31:0] tk_max;
  logic [63:0] tk_sum;
  logic [31:0] tk_count;

  stats_t      pending_stats [$];
  logic [31:0] sample_pool [POOL_SIZE];
  int          mismatches = 0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_tracker();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < DEPTH; i++) begin
        tk_value[s][i] = '0;
        tk_hits[s][i]  = '0;
        tk_used[s][i]  = 1'b0;
      end
    end
    tk_min   = '1;
    tk_max   = '0;
    tk_sum   = '0;
    tk_count = '0;
  endfunction

  function automatic void insert_sorted(int side, logic [31:0] v);
    bit done;
    bit ahead;
    done = 1'b0;
    for (int i = 0; i < DEPTH && !done; i++) begin
      if (tk_used[side][i] && tk_value[side][i] == v) begin
        if (tk_hits[side][i] != '1) tk_hits[side][i] = tk_hits[side][i] + 1;
        done = 1'b1;
      end else begin
        ahead = !tk_used[side][i] ||
                (side == 1 ? (v > tk_value[side][i]) : (v < tk_value[side][i]));
        if (ahead) begin
          for (int j = DEPTH - 1; j > i; j--) begin
            tk_value[side][j] = tk_value[side][j-1];
            tk_hits[side][j]  = tk_hits[side][j-1];
            tk_used[side][j]  = tk_used[side][j-1];
          end
          tk_value[side][i] = v;
          tk_hits[side][i]  = 32'd1;
          tk_used[side][i]  = 1'b1;
          done = 1'b1;
        end
      end
    end
  endfunction

  function automatic stats_t predict_stats(probe_t p);
    stats_t      r;
    logic [64:0] s;
    int          side;
    r = '0;
    if (p.cmd == lktk_pkg::CMD_RECORD) begin
      s = {1'b0, tk_sum} + {33'd0, p.lat};
      tk_sum = s[64] ? '1 : s[63:0];
      if (tk_count != '1) tk_count = tk_count + 1;
      if (p.lat < tk_min) tk_min = p.lat;
      if (p.lat > tk_max) tk_max = p.lat;
      insert_sorted(0, p.lat);
      insert_sorted(1, p.lat);
    end else if (p.idx < DEPTH) begin
      side = (p.tbl == lktk_pkg::TABLE_HIGH) ? 1 : 0;
      if (tk_used[side][p.idx]) begin
        r.entry_valid   = 1'b1;
        r.entry_latency = tk_value[side][p.idx];
        r.entry_hits    = tk_hits[side][p.idx];
      end
    end
    r.min_latency   = tk_min;
    r.max_latency   = tk_max;
    r.total_latency = tk_sum;
    r.sample_total  = tk_count;
    return r;
  endfunction

  // mostly values that repeat or land near the table edges, some full-range noise
  function automatic logic [31:0] pick_sample();
    int side;
    int pos;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_pool[$urandom_range(0, POOL_SIZE - 1)];
      4, 5:       return $urandom;
      6:          return $urandom_range(0, 40);
      7:          return 32'hFFFF_FFFF - $urandom_range(0, 40);
      8:          return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: begin
        side = $urandom_range(0, 1);
        pos  = $urandom_range(0, DEPTH - 1);
        return tk_used[side][pos] ? tk_value[side][pos] : $urandom;
      end
    endcase
  endfunction

  task automatic offer(probe_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= p.cmd;
    in_sample_latency <= p.lat;
    in_read_table     <= p.tbl;
    in_read_index     <= p.idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic void check_stats(stats_t want);
    if (out_entry_valid !== want.entry_valid) begin
      $error("entry_valid: expected %0h, got %0h", want.entry_valid, out_entry_valid);
      mismatches++;
    end
    if (out_entry_latency !== want.entry_latency) begin
      $error("entry_latency: expected %0h, got %0h", want.entry_latency, out_entry_latency);
      mismatches++;
    end
    if (out_entry_hits !== want.entry_hits) begin
      $error("entry_hits: expected %0h, got %0h", want.entry_hits, out_entry_hits);
      mismatches++;
    end
    if (out_min_latency !== want.min_latency) begin
      $error("min_latency: expected %0h, got %0h", want.min_latency, out_min_latency);
      mismatches++;
    end
    if (out_max_latency !== want.max_latency) begin
      $error("max_latency: expected %0h, got %0h", want.max_latency, out_max_latency);
      mismatches++;
    end
    if (out_total_latency !== want.total_latency) begin
      $error("total_latency: expected %0h, got %0h", want.total_latency, out_total_latency);
      mismatches++;
    end
    if (out_sample_total !== want.sample_total) begin
      $error("sample_total: expected %0h, got %0h", want.sample_total, out_sample_total);
      mismatches++;
    end
  endfunction

  // result side: random stalls per transaction, one long hold-off on request
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_stats.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        check_stats(pending_stats.pop_front());
      end
    end
  end

  initial begin
    probe_t item;
    stats_t want;
    clear_tracker();
    sample_pool[0] = 32'd0;
    sample_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++)
      sample_pool[i] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      offer(DIRECTED_PLAN[r].item);
      want = predict_stats(DIRECTED_PLAN[r].item);
      pending_stats.push_back(DIRECTED_PLAN[r].typed ? DIRECTED_PLAN[r].want : want);
    end

    for (int k = 0; k < RAND_ITEMS; k++) begin
      calm = (k >= 300 && k < 400) || (k >= 700 && k < 800);
      // sender keeps pushing while the result side is held off
      if (k == 700) hold_req = 1'b1;
      item.tbl = $urandom_range(0, 1) ? lktk_pkg::TABLE_HIGH : lktk_pkg::TABLE_LOW;
      item.idx = $urandom_range(0, 6) == 0 ? 4'($urandom_range(DEPTH, 15))
                                           : 4'($urandom_range(0, DEPTH - 1));
      if ($urandom_range(0, 19) < 11) begin
        item.cmd = lktk_pkg::CMD_RECORD;
        item.lat = pick_sample();
      end else begin
        item.cmd = lktk_pkg::CMD_READ;
        item.lat = $urandom;
      end
      offer(item);
      pending_stats.push_back(predict_stats(item));
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DEPTH * 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
